### hdl/jfts_pkg.sv
// ----------------------------------------------------------------------------
// jfts_pkg
// Shared types, codes and constants of the JPEG frame type scanner.
// ----------------------------------------------------------------------------
package jfts_pkg;

  localparam int DATA_W = 8;
  localparam int SIZE_W = 20;
  localparam int SKIP_W = 16;
  localparam int PH_W   = 3;
  localparam int KIND_W = 2;

  localparam int MAX_BUFFER_BYTES_DEF = 524288;

  localparam logic [SIZE_W-1:0] POS_MAX = {SIZE_W{1'b1}};

  // scan phases
  localparam logic [PH_W-1:0] PH_SOI0 = 3'd0;
  localparam logic [PH_W-1:0] PH_SOI1 = 3'd1;
  localparam logic [PH_W-1:0] PH_LEAD = 3'd2;
  localparam logic [PH_W-1:0] PH_FILL = 3'd3;
  localparam logic [PH_W-1:0] PH_LENH = 3'd4;
  localparam logic [PH_W-1:0] PH_LENL = 3'd5;
  localparam logic [PH_W-1:0] PH_SKIP = 3'd6;

  // marker bytes
  localparam logic [DATA_W-1:0] MK_FF   = 8'hFF;
  localparam logic [DATA_W-1:0] MK_SOI  = 8'hD8;
  localparam logic [DATA_W-1:0] MK_SOS  = 8'hDA;
  localparam logic [DATA_W-1:0] MK_EOI  = 8'hD9;
  localparam logic [DATA_W-1:0] MK_ZERO = 8'h00;
  localparam logic [DATA_W-1:0] MK_TEM  = 8'h01;
  localparam logic [DATA_W-1:0] MK_RST0 = 8'hD0;
  localparam logic [DATA_W-1:0] MK_RST7 = 8'hD7;
  localparam logic [DATA_W-1:0] MK_SOF0 = 8'hC0;
  localparam logic [DATA_W-1:0] MK_SOF2 = 8'hC2;

  // result codes
  localparam logic [KIND_W-1:0] KIND_INVALID     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BASELINE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PROGRESSIVE = 2'd2;

  typedef struct packed {
    logic [PH_W-1:0]   scan_phase;
    logic [SIZE_W-1:0] byte_position;
    logic [DATA_W-1:0] pending_marker;
    logic [DATA_W-1:0] length_high;
    logic [SKIP_W-1:0] skip_remaining;
    logic              verdict_given;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_RST = '{
    scan_phase:     PH_SOI0,
    byte_position:  '0,
    pending_marker: '0,
    length_high:    '0,
    skip_remaining: '0,
    verdict_given:  1'b0
  };

endpackage

### hdl/jpeg_frame_type_scanner.sv
// ----------------------------------------------------------------------------
// jpeg_frame_type_scanner
// Walks the marker segments of a JPEG buffer fed one byte per transfer and
// reports whether its first frame header is baseline or progressive. The block
// takes one byte per cycle unless stalled; a byte passes an input register
// and the marker walk logic, and any result is registered in an output
// register. The input register stalls only when a byte would produce a
// result while the output register still holds one that has not been taken.
// Exactly one result (0 invalid, 1 baseline, 2 progressive) is given per
// buffer, either as soon as the verdict is known or on the byte marked
// end_of_buffer; all scan state clears after that byte.
// ----------------------------------------------------------------------------
module jpeg_frame_type_scanner #(
  parameter int MAX_BUFFER_BYTES = jfts_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [jfts_pkg::DATA_W-1:0]   in_data_byte,
  input  logic [jfts_pkg::SIZE_W-1:0]   in_total_size,
  input  logic                          in_end_of_buffer,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [jfts_pkg::KIND_W-1:0]   out_frame_kind
);
  import jfts_pkg::*;

  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_byte_r;
  logic [SIZE_W-1:0] s1_size_r;
  logic              s1_eob_r;
  scan_state_t       st_r;
  scan_state_t       st_nxt;
  logic              step_emit;
  logic [KIND_W-1:0] step_kind;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_free;
  logic              s1_go;

  jfts_step #(
    .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
  ) u_step (
    .cur           (st_r),
    .data_byte     (s1_byte_r),
    .total_size    (s1_size_r),
    .end_of_buffer (s1_eob_r),
    .nxt           (st_nxt),
    .emit          (step_emit),
    .kind          (step_kind)
  );

  assign out_free = !out_valid_r || out_ready;
  // hold the byte only if its result has nowhere to go
  assign s1_go    = s1_valid_r && (!step_emit || out_free);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_size_r <= in_total_size;
      s1_eob_r  <= in_end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SCAN_STATE_RST;
    end else if (s1_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && step_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && step_emit) begin
      out_kind_r <= step_kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_kind = out_kind_r;

endmodule

### hdl/jfts_step.sv
// ----------------------------------------------------------------------------
// jfts_step
// Next-state and verdict logic for one buffer byte.
// ----------------------------------------------------------------------------
module jfts_step #(
  parameter int MAX_BUFFER_BYTES = jfts_pkg::MAX_BUFFER_BYTES_DEF
) (
  input  jfts_pkg::scan_state_t             cur,
  input  logic [jfts_pkg::DATA_W-1:0]       data_byte,
  input  logic [jfts_pkg::SIZE_W-1:0]       total_size,
  input  logic                              end_of_buffer,
  output jfts_pkg::scan_state_t             nxt,
  output logic                              emit,
  output logic [jfts_pkg::KIND_W-1:0]       kind
);
  import jfts_pkg::*;

  logic              decided;
  logic [KIND_W-1:0] dec_kind;
  logic [SIZE_W:0]   size_x;
  logic [SIZE_W:0]   pos_x;
  logic [SIZE_W:0]   room;
  logic [SKIP_W-1:0] seg_len;
  logic [SKIP_W-1:0] skip_dec;
  logic              bad_size;
  logic              no_len_room;

  assign size_x      = {1'b0, total_size};
  assign pos_x       = {1'b0, cur.byte_position};
  assign bad_size    = (total_size < SIZE_W'(4)) ||
                       (size_x > (SIZE_W+1)'(MAX_BUFFER_BYTES)) ||
                       (cur.byte_position >= total_size);
  // fewer than two bytes left after this one
  assign no_len_room = (pos_x + (SIZE_W+1)'(3)) > size_x;
  // bytes from the length's high byte to the end of the buffer
  assign room        = size_x - pos_x + (SIZE_W+1)'(1);
  assign seg_len     = {cur.length_high, data_byte};
  assign skip_dec    = (cur.skip_remaining != '0) ? cur.skip_remaining - SKIP_W'(1)
                                                  : cur.skip_remaining;

  always_comb begin
    nxt      = cur;
    decided  = 1'b0;
    dec_kind = KIND_INVALID;
    if (!cur.verdict_given) begin
      if (bad_size) begin
        decided = 1'b1;
      end else begin
        unique case (cur.scan_phase)
          PH_SOI0: begin
            if (data_byte != MK_FF) decided = 1'b1;
            else nxt.scan_phase = PH_SOI1;
          end
          PH_SOI1: begin
            if (data_byte != MK_SOI) decided = 1'b1;
            else nxt.scan_phase = PH_LEAD;
          end
          PH_LEAD: begin
            if (data_byte != MK_FF) decided = 1'b1;
            else nxt.scan_phase = PH_FILL;
          end
          PH_FILL: begin
            priority if (data_byte == MK_FF) begin
              nxt.scan_phase = PH_FILL;
            end else if (data_byte == MK_SOS || data_byte == MK_EOI ||
                         data_byte == MK_ZERO) begin
              decided = 1'b1;
            end else if (data_byte == MK_TEM ||
                         (data_byte >= MK_RST0 && data_byte <= MK_RST7)) begin
              nxt.scan_phase = PH_LEAD;
            end else if (no_len_room) begin
              decided = 1'b1;
            end else begin
              nxt.pending_marker = data_byte;
              nxt.scan_phase     = PH_LENH;
            end
          end
          PH_LENH: begin
            nxt.length_high = data_byte;
            nxt.scan_phase  = PH_LENL;
          end
          PH_LENL: begin
            priority if (seg_len < SKIP_W'(2) ||
                         {{(SIZE_W+1-SKIP_W){1'b0}}, seg_len} > room) begin
              decided = 1'b1;
            end else if (cur.pending_marker == MK_SOF0) begin
              decided  = 1'b1;
              dec_kind = KIND_BASELINE;
            end else if (cur.pending_marker == MK_SOF2) begin
              decided  = 1'b1;
              dec_kind = KIND_PROGRESSIVE;
            end else if (seg_len == SKIP_W'(2)) begin
              nxt.scan_phase = PH_LEAD;
            end else begin
              nxt.skip_remaining = seg_len - SKIP_W'(2);
              nxt.scan_phase     = PH_SKIP;
            end
          end
          PH_SKIP: begin
            nxt.skip_remaining = skip_dec;
            if (skip_dec == '0) nxt.scan_phase = PH_LEAD;
          end
          default: begin
            decided = 1'b1;
          end
        endcase
      end
    end

    nxt.verdict_given = cur.verdict_given | decided;
    if (end_of_buffer) begin
      nxt = SCAN_STATE_RST;
    end else if (cur.byte_position != POS_MAX) begin
      nxt.byte_position = cur.byte_position + SIZE_W'(1);
    end
  end

  // one result per buffer: at the verdict, or on the last byte
  assign emit = !cur.verdict_given && (decided || end_of_buffer);
  assign kind = decided ? dec_kind : KIND_INVALID;

endmodule

### hdl/jfts_checker.sv
// ----------------------------------------------------------------------------
// jfts_checker
// Port-level checks on the scanner's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module jfts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [jfts_pkg::KIND_W-1:0] out_frame_kind
);
  import jfts_pkg::*;

  // nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no code beyond progressive ever leaves the block
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_kind == KIND_INVALID || out_frame_kind == KIND_BASELINE ||
                   out_frame_kind == KIND_PROGRESSIVE))
    else $error("illegal frame kind");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_kind))
    else $error("stalled result changed");

  // with the output empty and the input side idle across the antecedent no result can appear
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) ##1 !out_valid && !(in_valid && in_ready)
    |=> !out_valid)
    else $error("result without a byte");

endmodule

bind jpeg_frame_type_scanner jfts_checker u_jfts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_kind (out_frame_kind)
);

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds JPEG-like byte streams to the frame type scanner. Well-formed buffers
// get random segments, fill bytes and standalone markers, and some buffers get
// a flaw: a bad marker, a bad length, a wrong size or an early end. Each
// accepted byte goes through a predictor. Every frame kind that comes out is
// compared with the oldest predicted one. The run cycles through phases of
// sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import jfts_pkg::*;

  // Predicts the frame kind of each buffer from the bytes accepted so far.
  class frame_kind_scoreboard;
    logic [PH_W-1:0]   walk_phase;
    logic [SIZE_W-1:0] byte_pos;
    logic [DATA_W-1:0] seg_marker;
    logic [DATA_W-1:0] len_hi;
    logic [SKIP_W-1:0] skip_left;
    bit                verdict_done;
    logic [KIND_W-1:0] kinds_due[$];
    int                errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      walk_phase   = PH_SOI0;
      byte_pos     = '0;
      seg_marker   = '0;
      len_hi       = '0;
      skip_left    = '0;
      verdict_done = 1'b0;
    endfunction

    function int pending();
      return kinds_due.size();
    endfunction

    function void note_byte(logic [DATA_W-1:0] d, logic [SIZE_W-1:0] sz, logic eob);
      bit                decided;
      bit                emit;
      logic [KIND_W-1:0] kind;
      int                p;
      int                seg_len;
      int                room;
      decided = 1'b0;
      emit    = 1'b0;
      kind    = KIND_INVALID;
      if (!verdict_done) begin
        p = int'(byte_pos);
        if (sz < 4 || sz > MAX_BUFFER_BYTES_DEF || p >= int'(sz)) begin
          decided = 1'b1;
        end else begin
          case (walk_phase)
            PH_SOI0: begin
              if (d != MK_FF) decided = 1'b1;
              else walk_phase = PH_SOI1;
            end
            PH_SOI1: begin
              if (d != MK_SOI) decided = 1'b1;
              else walk_phase = PH_LEAD;
            end
            PH_LEAD: begin
              if (d != MK_FF) decided = 1'b1;
              else walk_phase = PH_FILL;
            end
            PH_FILL: begin
              if (d == MK_FF) begin
                // fill byte: stay
              end else if (d == MK_SOS || d == MK_EOI || d == MK_ZERO) begin
                decided = 1'b1;
              end else if (d == MK_TEM || (d >= MK_RST0 && d <= MK_RST7)) begin
                walk_phase = PH_LEAD;
              end else if (int'(sz) - (p + 1) < 2) begin
                decided = 1'b1;
              end else begin
                seg_marker = d;
                walk_phase = PH_LENH;
              end
            end
            PH_LENH: begin
              len_hi     = d;
              walk_phase = PH_LENL;
            end
            PH_LENL: begin
              seg_len = int'({len_hi, d});
              room    = int'(sz) - (p - 1);
              if (seg_len < 2 || seg_len > room) begin
                decided = 1'b1;
              end else if (seg_marker == MK_SOF0) begin
                decided = 1'b1;
                kind    = KIND_BASELINE;
              end else if (seg_marker == MK_SOF2) begin
                decided = 1'b1;
                kind    = KIND_PROGRESSIVE;
              end else if (seg_len == 2) begin
                walk_phase = PH_LEAD;
              end else begin
                skip_left  = SKIP_W'(seg_len - 2);
                walk_phase = PH_SKIP;
              end
            end
            PH_SKIP: begin
              if (skip_left > 0) skip_left--;
              if (skip_left == 0) walk_phase = PH_LEAD;
            end
            default: decided = 1'b1;
          endcase
        end
        if (decided) begin
          verdict_done = 1'b1;
          emit         = 1'b1;
        end
      end
      if (eob) begin
        if (!verdict_done) begin
          emit = 1'b1;
          kind = KIND_INVALID;
        end
        clear();
      end else if (byte_pos < POS_MAX) begin
        byte_pos++;
      end
      if (emit) kinds_due.push_back(kind);
    endfunction

    function void check_kind(logic [KIND_W-1:0] got);
      logic [KIND_W-1:0] want;
      if (kinds_due.size() == 0) begin
        $display("%0t: frame_kind expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = kinds_due.pop_front();
        if (got !== want) begin
          $display("%0t: frame_kind expected %0d, actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [DATA_W-1:0]   in_data_byte;
  logic [SIZE_W-1:0]   in_total_size;
  logic                in_end_of_buffer;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   out_frame_kind;

  frame_kind_scoreboard book;
  int                   sender_idle_pct   = 0;
  int                   receiver_stall_pct = 0;
  int                   bytes_sent = 0;
  logic [DATA_W-1:0]    stream_q[$];
  int                   stream_size;
  int                   len_at;
  bit                   wobble;

  jpeg_frame_type_scanner uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_total_size    (in_total_size),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_kind   (out_frame_kind)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_kind(out_frame_kind);
  end

  // Entered and left at a falling edge.
  task automatic send_byte(logic [DATA_W-1:0] d, logic [SIZE_W-1:0] sz, logic eob);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_data_byte     = d;
    in_total_size    = sz;
    in_end_of_buffer = eob;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_byte(d, sz, eob);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    logic [SIZE_W-1:0] sz;
    for (int i = 0; i < stream_q.size(); i++) begin
      if (wobble && $urandom_range(0, 2) == 0) begin
        sz = SIZE_W'($urandom_range(0, MAX_BUFFER_BYTES_DEF));
      end else begin
        sz = SIZE_W'(stream_size);
      end
      send_byte(stream_q[i], sz, i == stream_q.size() - 1);
    end
  endtask

  task automatic push_marker(logic [DATA_W-1:0] m);
    stream_q.push_back(MK_FF);
    repeat ($urandom_range(0, 2)) stream_q.push_back(MK_FF);
    stream_q.push_back(m);
  endtask

  task automatic push_segment(logic [DATA_W-1:0] m, int seg_len);
    push_marker(m);
    len_at = stream_q.size();
    stream_q.push_back(seg_len[15:8]);
    stream_q.push_back(seg_len[7:0]);
    repeat (seg_len - 2) stream_q.push_back(DATA_W'($urandom_range(0, 255)));
  endtask

  // A marker that opens an ordinary segment with a length.
  function automatic logic [DATA_W-1:0] plain_marker();
    logic [DATA_W-1:0] m;
    do m = DATA_W'($urandom_range(0, 255));
    while (m == MK_FF || m == MK_SOS || m == MK_EOI || m == MK_ZERO || m == MK_TEM ||
           (m >= MK_RST0 && m <= MK_RST7) || m == MK_SOF0 || m == MK_SOF2);
    return m;
  endfunction

  task automatic build_stream();
    int flaw;
    int cut;
    stream_q = {MK_FF, MK_SOI};
    len_at   = -1;
    wobble   = 1'b0;
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 2))
        0:       push_marker(MK_TEM);
        1:       push_marker(MK_RST0 + DATA_W'($urandom_range(0, 7)));
        default: push_segment(plain_marker(), $urandom_range(2, 12));
      endcase
    end
    case ($urandom_range(0, 4))
      0, 1:    push_segment(MK_SOF0, $urandom_range(2, 12));
      2, 3:    push_segment(MK_SOF2, $urandom_range(2, 12));
      default: ; // no frame header: the walk runs into the end
    endcase
    repeat ($urandom_range(0, 4)) stream_q.push_back(DATA_W'($urandom_range(0, 255)));
    stream_size = stream_q.size();
    flaw = ($urandom_range(0, 99) < 45) ? $urandom_range(1, 8) : 0;
    case (flaw)
      1: stream_q[$urandom_range(0, stream_q.size() - 1)] = DATA_W'($urandom_range(0, 255));
      2: if (len_at >= 0) begin
        case ($urandom_range(0, 2))
          0:       stream_q[len_at - 1] = MK_SOS;
          1:       stream_q[len_at - 1] = MK_EOI;
          default: stream_q[len_at - 1] = MK_ZERO;
        endcase
      end
      3: if (len_at >= 0) begin
        stream_q[len_at]     = 8'h00;
        stream_q[len_at + 1] = DATA_W'($urandom_range(0, 1));
      end
      4: if (len_at >= 0) begin
        // wide length against a large size: long skips or overruns
        stream_q[len_at]     = DATA_W'($urandom_range(0, 255));
        stream_q[len_at + 1] = DATA_W'($urandom_range(0, 255));
        stream_size = $urandom_range(0, 1) ? MAX_BUFFER_BYTES_DEF :
                      $urandom_range(stream_size, MAX_BUFFER_BYTES_DEF);
      end
      5: stream_size = $urandom_range(0, 1) ? stream_size + $urandom_range(1, 40) :
                       $urandom_range(stream_size + 1, MAX_BUFFER_BYTES_DEF);
      6: stream_size = $urandom_range(0, stream_size - 1);
      7: begin
        cut = $urandom_range(1, stream_q.size() - 1);
        while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
      8: wobble = 1'b1;
      default: ;
    endcase
  endtask

  task automatic run_phase(int idle, int stall, int target);
    int start;
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      build_stream();
      send_stream();
    end
    // hold off until every predicted kind has been taken
    in_valid = 1'b0;
    while (book.pending() != 0) @(negedge clk);
  endtask

  initial begin
    book             = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data_byte     = '0;
    in_total_size    = '0;
    in_end_of_buffer = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n  = 1'b1;
    wobble = 1'b0;

    // buffer under four bytes
    stream_q = {MK_FF, MK_SOI, MK_FF};
    stream_size = 3;
    send_stream();
    // fill, RST7 and TEM before a progressive header
    stream_q = {MK_FF, MK_SOI, MK_FF, MK_RST7, MK_FF, MK_TEM, MK_FF, MK_FF, MK_SOF2,
                8'h00, 8'h02};
    stream_size = 11;
    send_stream();
    // no room left for a length
    stream_q = {MK_FF, MK_SOI, MK_FF, MK_SOF0};
    stream_size = 4;
    send_stream();
    // smallest baseline buffer
    stream_q = {MK_FF, MK_SOI, MK_FF, MK_SOF0, 8'h00, 8'h02};
    stream_size = 6;
    send_stream();
    // truncated buffer
    stream_q = {MK_FF, MK_SOI};
    stream_size = 20;
    send_stream();

    run_phase(0, 0, 375);
    run_phase(77, 0, 375);
    run_phase(0, 77, 375);
    run_phase(14, 14, 375);

    while (book.pending() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
